// ===== hw/rtl/fprd_pkg.sv =====
// ----------------------------------------------------------------------------
// fprd_pkg
// Shared types and constants of the FMCW peak range detector.
// ----------------------------------------------------------------------------
package fprd_pkg;

   // frame limits
   localparam int MAX_BINS  = 128;
   localparam int BIN_CNT_W = $clog2(MAX_BINS + 1);
   localparam int INDEX_W   = 16;

   // frame summary queue between front and back; five slots, while the three
   // stage pipe holds at most three frames in flight
   localparam int QUEUE_DEPTH = 5;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 64;
   localparam logic [CSR_INDEX_W-1:0] CSR_METERS_PER_BIN  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_POWER_THRESHOLD = 1'd1;
   localparam logic [31:0] METERS_PER_BIN_RESET  = 32'd65536;
   localparam logic [63:0] POWER_THRESHOLD_RESET = 64'd2882303762;

   // input item
   typedef struct packed {
      logic signed [31:0] bin_re;
      logic signed [31:0] bin_im;
      logic               last_bin;
   } req_type;

   // result item
   typedef struct packed {
      logic [47:0]        range_value;
      logic               detected;
      logic [INDEX_W-1:0] peak_index;
      logic [63:0]        peak_power;
   } rsp_type;

   // peak of one finished frame
   typedef struct packed {
      logic [INDEX_W-1:0] peak_index;
      logic [63:0]        peak_power;
   } frame_type;

   // queue status seen by front and back
   typedef struct packed {
      logic [QCNT_W-1:0] fill;
      logic              empty;
   } qstat_type;

endpackage

// ===== hw/rtl/fprd_front.sv =====
// ----------------------------------------------------------------------------
// fprd_front
// Accepts bins, forms power in a three stage pipe and tracks the frame peak.
// ----------------------------------------------------------------------------
module fprd_front import fprd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_stall,
   input  req_type   req_payload,
   input  qstat_type q_stat,
   output logic      push_valid,
   output frame_type push_frame
);

   // bin counter
   logic [BIN_CNT_W-1:0] cnt_ff, cnt_in;

   // stage 1: magnitudes
   logic               s1_valid_ff, s1_valid_in;
   logic               s1_last_ff, s1_use_ff;
   logic [INDEX_W-1:0] s1_idx_ff;
   logic [31:0]        s1_mag_re_ff, s1_mag_im_ff;

   // stage 2: squares
   logic               s2_valid_ff;
   logic               s2_last_ff, s2_use_ff;
   logic [INDEX_W-1:0] s2_idx_ff;
   logic [63:0]        s2_sq_re_ff, s2_sq_im_ff;

   // stage 3: power
   logic               s3_valid_ff;
   logic               s3_last_ff, s3_use_ff;
   logic [INDEX_W-1:0] s3_idx_ff;
   logic [63:0]        s3_sum_ff;

   // running peak
   logic [63:0]        best_power_ff, best_power_in;
   logic [INDEX_W-1:0] best_index_ff, best_index_in;

   logic               accept;
   logic               use_bin;
   logic [31:0]        mag_re, mag_im;
   logic [QCNT_W:0]    lasts_in_pipe;
   logic [QCNT_W:0]    committed;
   logic               hit;

   // stall when every queue slot is spoken for by stored or in-flight frames
   always_comb begin
      lasts_in_pipe = (QCNT_W+1)'(s1_valid_ff & s1_last_ff)
                    + (QCNT_W+1)'(s2_valid_ff & s2_last_ff)
                    + (QCNT_W+1)'(s3_valid_ff & s3_last_ff);
      committed     = {1'b0, q_stat.fill} + lasts_in_pipe;
      req_stall     = committed >= (QCNT_W+1)'(QUEUE_DEPTH);
   end

   // accept and bin numbering
   always_comb begin
      accept      = req_valid && !req_stall;
      use_bin     = cnt_ff < BIN_CNT_W'(MAX_BINS);
      s1_valid_in = accept;
      cnt_in      = cnt_ff;
      if (accept) begin
         if (req_payload.last_bin) begin
            cnt_in = '0;
         end else if (use_bin) begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   // absolute values, the most negative input wraps to 2^31 as wanted
   always_comb begin
      mag_re = req_payload.bin_re[31] ? (32'd0 - req_payload.bin_re) : req_payload.bin_re;
      mag_im = req_payload.bin_im[31] ? (32'd0 - req_payload.bin_im) : req_payload.bin_im;
   end

   // peak compare, strictly greater replaces
   always_comb begin
      hit           = s3_valid_ff && s3_use_ff && (s3_sum_ff > best_power_ff);
      push_valid    = s3_valid_ff && s3_last_ff;
      push_frame.peak_power = hit ? s3_sum_ff : best_power_ff;
      push_frame.peak_index = hit ? s3_idx_ff : best_index_ff;
      best_power_in = best_power_ff;
      best_index_in = best_index_ff;
      if (push_valid) begin
         best_power_in = '0;
         best_index_in = '0;
      end else if (hit) begin
         best_power_in = s3_sum_ff;
         best_index_in = s3_idx_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff        <= '0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         best_power_ff <= '0;
         best_index_ff <= '0;
      end else begin
         cnt_ff        <= cnt_in;
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s1_valid_ff;
         s3_valid_ff   <= s2_valid_ff;
         best_power_ff <= best_power_in;
         best_index_ff <= best_index_in;
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      s1_last_ff   <= req_payload.last_bin;
      s1_use_ff    <= use_bin;
      s1_idx_ff    <= INDEX_W'(cnt_ff);
      s1_mag_re_ff <= mag_re;
      s1_mag_im_ff <= mag_im;

      s2_last_ff   <= s1_last_ff;
      s2_use_ff    <= s1_use_ff;
      s2_idx_ff    <= s1_idx_ff;
      s2_sq_re_ff  <= 64'(s1_mag_re_ff) * 64'(s1_mag_re_ff);
      s2_sq_im_ff  <= 64'(s1_mag_im_ff) * 64'(s1_mag_im_ff);

      s3_last_ff   <= s2_last_ff;
      s3_use_ff    <= s2_use_ff;
      s3_idx_ff    <= s2_idx_ff;
      s3_sum_ff    <= s2_sq_re_ff + s2_sq_im_ff;
   end

endmodule

// ===== hw/rtl/fprd_queue.sv =====
// ----------------------------------------------------------------------------
// fprd_queue
// Short queue of finished frame peaks between front and back.
// ----------------------------------------------------------------------------
module fprd_queue import fprd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   input  frame_type push_frame,
   input  logic      pop,
   output frame_type head_frame,
   output qstat_type q_stat
);

   frame_type         entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] fill_ff, fill_in;

   // pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_valid && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push_valid) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_frame;
      end
   end

   assign head_frame   = entry_ff[rd_ptr_ff];
   assign q_stat.fill  = fill_ff;
   assign q_stat.empty = (fill_ff == '0);

endmodule

// ===== hw/rtl/fprd_back.sv =====
// ----------------------------------------------------------------------------
// fprd_back
// Turns a frame peak into range and detect flag and holds the result item.
// ----------------------------------------------------------------------------
module fprd_back import fprd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  qstat_type   q_stat,
   input  frame_type   head_frame,
   output logic        pop,
   input  logic [31:0] meters_per_bin,
   input  logic [63:0] power_threshold,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_payload
);

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   logic    det;
   logic [47:0] range_raw;

   // take a frame whenever the output register is free or being emptied
   always_comb begin
      pop          = !q_stat.empty && (!rsp_valid_ff || !rsp_stall);
      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // detect compare and range multiply
   always_comb begin
      det                = head_frame.peak_power > power_threshold;
      range_raw          = 48'(head_frame.peak_index) * 48'(meters_per_bin);
      rsp_in.range_value = det ? range_raw : '0;
      rsp_in.detected    = det;
      rsp_in.peak_index  = head_frame.peak_index;
      rsp_in.peak_power  = head_frame.peak_power;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== hw/rtl/fmcw_peak_range_detect_top.sv =====
// ----------------------------------------------------------------------------
// fmcw_peak_range_detect_top
// Peak power search over a frame of spectrum bins with range conversion.
// ----------------------------------------------------------------------------
//  channel   ports                                  direction
//  req       req_valid, req_stall, req_payload      bins in
//  rsp       rsp_valid, rsp_stall, rsp_payload      frame result out
//  csr       csr_we, csr_index, csr_wdata           register writes in
//
//  One bin is accepted every cycle while req_stall is low; the front pipe
//  (magnitude, square, sum) runs one bin per cycle, and a frame result
//  passes the three pipe stages, the frame queue and the output register.
//  Results leave via the range multiplier, one per cycle if rsp_stall is low.
//  Synchronous reset clears frame state and restores register defaults.
//  req_stall rises only when stored plus in-flight frame results fill the
//  five-entry queue, that is when rsp_stall has held results back.
// ----------------------------------------------------------------------------
module fmcw_peak_range_detect_top import fprd_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_payload,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [31:0] meters_per_bin_ff, meters_per_bin_in;
   logic [63:0] power_threshold_ff, power_threshold_in;

   logic      push_valid;
   frame_type push_frame;
   frame_type head_frame;
   qstat_type q_stat;
   logic      pop;

   // configuration registers
   always_comb begin
      meters_per_bin_in  = meters_per_bin_ff;
      power_threshold_in = power_threshold_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_METERS_PER_BIN:  meters_per_bin_in  = csr_wdata[31:0];
            CSR_POWER_THRESHOLD: power_threshold_in = csr_wdata[63:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         meters_per_bin_ff  <= METERS_PER_BIN_RESET;
         power_threshold_ff <= POWER_THRESHOLD_RESET;
      end else begin
         meters_per_bin_ff  <= meters_per_bin_in;
         power_threshold_ff <= power_threshold_in;
      end
   end

   fprd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_stat      (q_stat),
      .push_valid  (push_valid),
      .push_frame  (push_frame)
   );

   fprd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_frame (push_frame),
      .pop        (pop),
      .head_frame (head_frame),
      .q_stat     (q_stat)
   );

   fprd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_stat          (q_stat),
      .head_frame      (head_frame),
      .pop             (pop),
      .meters_per_bin  (meters_per_bin_ff),
      .power_threshold (power_threshold_ff),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_payload     (rsp_payload)
   );

`ifndef NO_ASSERTIONS
   // queue never holds more frames than it has slots
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_stat.fill <= QCNT_W'(QUEUE_DEPTH))
      else $error("frame queue overfilled");

   // a full queue must hold off new bins
   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      (q_stat.fill == QCNT_W'(QUEUE_DEPTH)) |-> req_stall)
      else $error("bin accepted with full queue");

   // no push into a full queue unless a pop frees a slot
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push_valid && (q_stat.fill == QCNT_W'(QUEUE_DEPTH))) |-> pop)
      else $error("push into full queue");

   // an undetected result carries zero range
   a_zero_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.detected) |-> (rsp_payload.range_value == '0))
      else $error("range set without detection");
`endif

endmodule

// ===== test/tb_fmcw_peak_range_detect_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fmcw_peak_range_detect_top
// Self-checking bench for the FMCW peak range detector. Frames of spectrum
// bins are streamed in with random gaps and output back-pressure. A local
// model tracks peak power, peak index and the range scale for each frame.
// Every frame result is compared field by field against that prediction.
// ----------------------------------------------------------------------------
module tb_fmcw_peak_range_detect_top;
   import fprd_pkg::*;

   localparam int ITEM_TARGET    = 1850;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = 12;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   req_type                req_payload;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_payload;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // model state: register copies and running frame peak
   logic [31:0]  model_mpb;
   logic [63:0]  model_thr;
   int unsigned  frame_bins;
   logic [63:0]  peak_pow;
   logic [15:0]  peak_idx;

   rsp_type      pending_results[$];
   int unsigned  items_sent;
   int unsigned  mismatches;
   int unsigned  idle_cycles;
   bit           gaps_on;
   bit           stall_on;

   // rsp_stall pattern state
   int unsigned  stall_left;
   logic         stall_next;
   int unsigned  pick;

   fmcw_peak_range_detect_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // squared magnitude of one signed part; the most negative value gives 2^62
   function automatic logic [63:0] part_square(input logic signed [31:0] v);
      logic [31:0] mag;
      mag = v[31] ? (~v + 32'd1) : v;
      return 64'(mag) * 64'(mag);
   endfunction

   // fold one accepted bin into the frame peak, close the frame on last
   task automatic track_bin(input req_type b);
      logic [63:0] p;
      rsp_type     r;
      if (frame_bins < MAX_BINS) begin
         p = part_square(b.bin_re) + part_square(b.bin_im);
         if (p > peak_pow) begin
            peak_pow = p;
            peak_idx = frame_bins[15:0];
         end
         frame_bins++;
      end
      if (b.last_bin) begin
         r.detected    = (peak_pow > model_thr);
         r.range_value = r.detected ? 48'(peak_idx) * 48'(model_mpb) : 48'd0;
         r.peak_index  = peak_idx;
         r.peak_power  = peak_pow;
         pending_results.push_back(r);
         frame_bins = 0;
         peak_pow   = 64'd0;
         peak_idx   = 16'd0;
      end
   endtask

   function automatic req_type make_bin(input logic signed [31:0] re,
                                        input logic signed [31:0] im,
                                        input logic last);
      req_type b;
      b.bin_re   = re;
      b.bin_im   = im;
      b.last_bin = last;
      return b;
   endfunction

   // random part value: extremes now and then, otherwise a random magnitude
   function automatic logic signed [31:0] random_part();
      int unsigned r;
      r = $urandom_range(0, 19);
      case (r)
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return 32'sh0;
         3: return -32'sd1;
         default: return $signed(32'($urandom)) >>> $urandom_range(0, 31);
      endcase
   endfunction

   // sender idle cycles, noise on the payload while valid is low
   task automatic idle_gap();
      int unsigned n;
      int unsigned r;
      n = 0;
      if (gaps_on) begin
         r = $urandom_range(0, 99);
         if (r >= 96)      n = $urandom_range(10, 30);
         else if (r >= 60) n = $urandom_range(1, 3);
      end
      repeat (n) begin
         @(negedge clock);
         req_valid   <= 1'b0;
         req_payload <= req_type'({$urandom, $urandom, 1'($urandom)});
      end
   endtask

   // send one bin and wait for the handshake
   task automatic send_bin(input req_type b);
      idle_gap();
      @(negedge clock);
      req_valid   <= 1'b1;
      req_payload <= b;
      do @(posedge clock); while (req_stall);
      track_bin(b);
      items_sent++;
   endtask

   // stop sending and wait until every frame result is back
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // register write, only with the block idle
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      drain_results();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_METERS_PER_BIN) model_mpb = data[31:0];
      else                           model_thr = data;
   endtask

   // one frame of random bins, with repeated powers now and then
   task automatic send_random_frame(input int unsigned len);
      logic signed [31:0] re;
      logic signed [31:0] im;
      logic signed [31:0] prev_re;
      logic signed [31:0] prev_im;
      prev_re = 32'sh0;
      prev_im = 32'sh0;
      for (int unsigned i = 0; i < len; i++) begin
         if (i > 0 && $urandom_range(0, 9) == 0) begin
            // same power as the previous bin
            re = -prev_im;
            im = prev_re;
         end else begin
            re = random_part();
            im = random_part();
         end
         send_bin(make_bin(re, im, i == len - 1));
         prev_re = re;
         prev_im = im;
      end
   endtask

   // frames under the reset values of the registers, around the threshold
   task automatic test_reset_defaults();
      send_bin(make_bin(32'sd53687, 32'sd0, 1'b0));
      send_bin(make_bin(32'sd0, -32'sd53688, 1'b1));
      send_bin(make_bin(32'sd0, 32'sd53687, 1'b1));
   endtask

   // field extremes, ties and an all-zero frame
   task automatic test_field_extremes();
      write_reg(CSR_POWER_THRESHOLD, 64'd0);
      write_reg(CSR_METERS_PER_BIN, 64'h0000_0000_ffff_ffff);
      // most negative parts, single-bin frame
      send_bin(make_bin(32'sh8000_0000, 32'sh8000_0000, 1'b1));
      // tie between bins 2 and 3, the earlier one stays
      send_bin(make_bin(32'sd0, 32'sd0, 1'b0));
      send_bin(make_bin(32'sd1, 32'sd0, 1'b0));
      send_bin(make_bin(32'sh7fff_ffff, 32'sd0, 1'b0));
      send_bin(make_bin(32'sd0, 32'sh7fff_ffff, 1'b0));
      send_bin(make_bin(-32'sd1, -32'sd1, 1'b1));
      // all bins zero, zero power is not above a zero threshold
      send_bin(make_bin(32'sd0, 32'sd0, 1'b0));
      send_bin(make_bin(32'sd0, 32'sd0, 1'b0));
      send_bin(make_bin(32'sd0, 32'sd0, 1'b1));
   endtask

   // detection edges and scale extremes
   task automatic test_threshold_edges();
      // peak equal to the threshold is not detected
      write_reg(CSR_POWER_THRESHOLD, 64'h8000_0000_0000_0000);
      send_bin(make_bin(32'sh8000_0000, 32'sh8000_0000, 1'b0));
      send_bin(make_bin(32'sd0, 32'sd0, 1'b1));
      write_reg(CSR_POWER_THRESHOLD, 64'h7fff_ffff_ffff_ffff);
      send_bin(make_bin(32'sd5, 32'sd5, 1'b0));
      send_bin(make_bin(32'sh8000_0000, 32'sh8000_0000, 1'b1));
      // zero scale, upper data bits ignored
      write_reg(CSR_METERS_PER_BIN, {32'($urandom), 32'd0});
      write_reg(CSR_POWER_THRESHOLD, 64'd24);
      send_bin(make_bin(32'sd3, -32'sd4, 1'b0));
      send_bin(make_bin(-32'sd3, 32'sd5, 1'b1));
      write_reg(CSR_POWER_THRESHOLD, 64'd25);
      send_bin(make_bin(32'sd3, 32'sd4, 1'b1));
   endtask

   // frame past MAX_BINS with its strongest bin in the ignored tail
   task automatic test_long_frame();
      write_reg(CSR_METERS_PER_BIN, 64'd65536);
      write_reg(CSR_POWER_THRESHOLD, 64'd1000);
      for (int unsigned i = 0; i < MAX_BINS + 12; i++) begin
         if (i == MAX_BINS + 4)
            send_bin(make_bin(32'sh8000_0000, 32'sh8000_0000, 1'b0));
         else
            send_bin(make_bin($signed(32'($urandom)) >>> 12,
                              $signed(32'($urandom)) >>> 12, i == MAX_BINS + 11));
      end
   endtask

   // random frames over a sequence of register settings
   task automatic test_random_frames();
      int unsigned phase_end;
      int unsigned len;
      int unsigned r;
      logic [31:0] mpb;
      logic [63:0] thr;
      while (items_sent < ITEM_TARGET) begin
         r = $urandom_range(0, 5);
         case (r)
            0:       mpb = 32'd0;
            1:       mpb = 32'hffff_ffff;
            2:       mpb = 32'd65536;
            default: mpb = $urandom;
         endcase
         r = $urandom_range(0, 7);
         case (r)
            0:       thr = 64'd0;
            1:       thr = 64'h8000_0000_0000_0000;
            default: thr = {1'b0, 31'($urandom), 32'($urandom)} >> $urandom_range(0, 62);
         endcase
         if ($urandom_range(0, 3) != 0)
            write_reg(CSR_METERS_PER_BIN, {32'($urandom), mpb});
         if ($urandom_range(0, 3) != 0)
            write_reg(CSR_POWER_THRESHOLD, thr);
         gaps_on   = ($urandom_range(0, 3) != 0);
         stall_on  = ($urandom_range(0, 3) != 0);
         phase_end = items_sent + $urandom_range(80, 250);
         while (items_sent < phase_end && items_sent < ITEM_TARGET) begin
            r = $urandom_range(0, 19);
            if (r == 0)      len = $urandom_range(MAX_BINS - 2, MAX_BINS + 40);
            else if (r < 4)  len = 1;
            else             len = $urandom_range(2, 16);
            send_random_frame(len);
            // sender holds off until the result side is empty
            if ($urandom_range(0, 24) == 0) drain_results();
         end
      end
   endtask

   // result side back-pressure: runs of ready, short stalls, rare long ones
   always @(negedge clock) begin
      if (stall_left == 0) begin
         pick = $urandom_range(0, 99);
         if (!stall_on || pick < 55) begin
            stall_next = 1'b0;
            stall_left = $urandom_range(1, 12);
         end else if (pick < 96) begin
            stall_next = 1'b1;
            stall_left = $urandom_range(1, 3);
         end else begin
            stall_next = 1'b1;
            stall_left = $urandom_range(10, 40);
         end
      end
      stall_left--;
      rsp_stall <= stall_next;
   end

   // result check against the oldest predicted frame, plus watchdog
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $error("unexpected result: range_value %0h peak_index %0d",
                      rsp_payload.range_value, rsp_payload.peak_index);
               mismatches++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_payload.range_value !== want.range_value) begin
                  $error("range_value: expected %0h, actual %0h",
                         want.range_value, rsp_payload.range_value);
                  mismatches++;
               end
               if (rsp_payload.detected !== want.detected) begin
                  $error("detected: expected %0b, actual %0b",
                         want.detected, rsp_payload.detected);
                  mismatches++;
               end
               if (rsp_payload.peak_index !== want.peak_index) begin
                  $error("peak_index: expected %0d, actual %0d",
                         want.peak_index, rsp_payload.peak_index);
                  mismatches++;
               end
               if (rsp_payload.peak_power !== want.peak_power) begin
                  $error("peak_power: expected %0h, actual %0h",
                         want.peak_power, rsp_payload.peak_power);
                  mismatches++;
               end
            end
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   // test sequence
   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      csr_we      = 1'b0;
      csr_index   = CSR_METERS_PER_BIN;
      csr_wdata   = '0;
      model_mpb   = METERS_PER_BIN_RESET;
      model_thr   = POWER_THRESHOLD_RESET;
      frame_bins  = 0;
      peak_pow    = 64'd0;
      peak_idx    = 16'd0;
      items_sent  = 0;
      mismatches  = 0;
      idle_cycles = 0;
      stall_left  = 0;
      stall_next  = 1'b0;
      gaps_on     = 1'b0;
      stall_on    = 1'b1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      gaps_on = 1'b1;
      test_field_extremes();
      test_threshold_edges();
      test_long_frame();
      test_random_frames();

      drain_results();
      if (mismatches == 0 && pending_results.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
